/* rtl/itd_pkg.sv */
// ---------------------------------------------------------------------------
// itd_pkg: shared types and tables for the inverse 4x4 transform block
// Sample and intermediate types, control structs, state codes, the
// normalization table, position classes and the 1-D butterfly.
// ---------------------------------------------------------------------------
`default_nettype none

package itd_pkg;

    typedef logic signed [15:0] smp_t;
    typedef logic signed [31:0] wide_t;
    typedef wide_t [3:0]        wvec_t;
    typedef smp_t  [3:0]        svec_t;

    // tag that travels beside one row in the row pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
    } pctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROWS,
        ST_COLS,
        ST_SEND
    } state_t;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_QP    = 3'd1;
    localparam logic [2:0] CFG_WLOW  = 3'd2;
    localparam logic [2:0] CFG_WHIGH = 3'd3;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_XFORM = 2'd1;
    localparam logic [1:0] MODE_DEQ   = 2'd2;

    localparam logic [1:0]  MODE_RESET = MODE_FULL;
    localparam logic [5:0]  QP_RESET   = 6'd1;
    localparam logic [63:0] WEIGHT_RESET = 64'h1010_1010_1010_1010;

    // qp/6 as (qp*43)>>8, exact for 6-bit qp
    localparam logic [5:0] QP_DIV6_MUL = 6'd43;
    localparam logic [5:0] QP_SPLIT    = 6'd24;

    localparam wide_t ROUND_BIAS = 32'sd32;
    localparam int    VERT_SHIFT = 6;

    localparam logic [4:0] NORM_TAB [6][3] = '{
        '{5'd10, 5'd16, 5'd13},
        '{5'd11, 5'd18, 5'd14},
        '{5'd13, 5'd20, 5'd16},
        '{5'd14, 5'd23, 5'd18},
        '{5'd16, 5'd25, 5'd20},
        '{5'd18, 5'd29, 5'd23}
    };

    localparam logic [1:0] POS_CLASS [16] = '{
        2'd0, 2'd2, 2'd0, 2'd2,
        2'd2, 2'd1, 2'd2, 2'd1,
        2'd0, 2'd2, 2'd0, 2'd2,
        2'd2, 2'd1, 2'd2, 2'd1
    };

    function automatic wvec_t butterfly(input wvec_t v);
        wide_t v0;
        wide_t v1;
        wide_t v2;
        wide_t v3;
        wide_t s0;
        wide_t s1;
        wide_t s2;
        wide_t s3;
        wvec_t o;
        v0 = v[0];
        v1 = v[1];
        v2 = v[2];
        v3 = v[3];
        s0 = v0 + v2;
        s1 = v0 - v2;
        s2 = (v1 >>> 1) - v3;
        s3 = v1 + (v3 >>> 1);
        o[0] = s0 + s3;
        o[1] = s1 + s2;
        o[2] = s1 - s2;
        o[3] = s0 - s3;
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/itd_lane.sv */
// ---------------------------------------------------------------------------
// itd_lane: dequantization lane for one column
// Stage one forms the level scale, stage two multiplies and applies the
// qp-dependent rounding shift; transform-only mode passes the input through.
// ---------------------------------------------------------------------------
`default_nettype none

module itd_lane (
    input  wire logic         clk,
    input  wire itd_pkg::smp_t coef,
    input  wire logic [1:0]   cls,
    input  wire logic [7:0]   weight,
    input  wire logic [2:0]   qm,
    input  wire logic [3:0]   qe,
    input  wire logic         qp_low,
    input  wire logic         use_dq,
    output itd_pkg::wide_t    dq_val
);
    import itd_pkg::*;

    logic [12:0]        scale_reg;
    logic [12:0]        scale_next;
    smp_t               coef_reg;
    wide_t              dq_reg;
    wide_t              dq_next;
    logic signed [29:0] prod;
    wide_t              prod_w;
    wide_t              rnd;
    wide_t              deq;

    assign scale_next = 13'(NORM_TAB[qm][cls]) * 13'(weight);

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        coef_reg  <= coef;
        dq_reg    <= dq_next;
    end

    always_comb
    begin
        prod   = coef_reg * $signed({1'b0, scale_reg});
        prod_w = 32'(prod);
        rnd    = 32'sd1 <<< (4'd3 - qe);
        if (qp_low)
        begin
            deq = (prod_w + rnd) >>> (4'd4 - qe);
        end
        else
        begin
            deq = prod_w <<< (qe - 4'd4);
        end
        dq_next = use_dq ? deq : 32'(coef_reg);
    end

    assign dq_val = dq_reg;

endmodule

`default_nettype wire

/* rtl/itd_merge.sv */
// ---------------------------------------------------------------------------
// itd_merge: horizontal butterfly over the four lane outputs
// Combines one row from the lanes and wraps each result to 16 bits; in
// dequantize-only mode the lane values pass through wrapped.
// ---------------------------------------------------------------------------
`default_nettype none

module itd_merge (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire itd_pkg::pctl_t ctl_in,
    input  wire logic          bypass,
    input  wire itd_pkg::wvec_t lane_val,
    output itd_pkg::pctl_t     ctl_out,
    output itd_pkg::svec_t     row_out
);
    import itd_pkg::*;

    pctl_t ctl_reg;
    svec_t row_reg;
    svec_t row_next;
    wvec_t bf;

    always_comb
    begin
        bf = butterfly(lane_val);
        for (int c = 0; c < 4; c++)
        begin
            row_next[c] = bypass ? lane_val[c][15:0] : bf[c][15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign ctl_out = ctl_reg;
    assign row_out = row_reg;

endmodule

`default_nettype wire

/* rtl/inverse_4x4_integer_transform_dequant.sv */
// ---------------------------------------------------------------------------
// inverse_4x4_integer_transform_dequant: 4x4 inverse transform with dequant
// Collects four coefficient rows, dequantizes in four column lanes, runs the
// horizontal butterfly per row and the vertical butterfly per column as the mode
// selects, then sends four result rows.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  coeff_a..coeff_d
//   out      output     out_valid/out_stall out_a..out_d, out_row, block_last
//   cfg      input      cfg_we             cfg_index, cfg_data
//
// one row is taken per cycle while in_stall is low; after the fourth, the rows
// pass the issue counter, the lane and merge registers and the row array, and
// the column pass fills the result rows; input is held off until they are sent
// out_stall holds the current row and stretches the block for as long as it is high
// reset clears the row count and sequencer and loads the config registers with their defaults
// config is sampled when the fourth row is transferred
// ---------------------------------------------------------------------------
`default_nettype none

module inverse_4x4_integer_transform_dequant (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire itd_pkg::smp_t coeff_a,
    input  wire itd_pkg::smp_t coeff_b,
    input  wire itd_pkg::smp_t coeff_c,
    input  wire itd_pkg::smp_t coeff_d,
    output logic              out_valid,
    input  wire logic         out_stall,
    output itd_pkg::smp_t     out_a,
    output itd_pkg::smp_t     out_b,
    output itd_pkg::smp_t     out_c,
    output itd_pkg::smp_t     out_d,
    output logic [1:0]        out_row,
    output logic              block_last,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import itd_pkg::*;

    state_t       state_reg;
    state_t       state_next;

    logic [1:0]   mode_reg;
    logic [5:0]   qp_reg;
    logic [63:0]  wlow_reg;
    logic [63:0]  whigh_reg;

    logic         dq_snap_reg;
    logic         bypass_snap_reg;
    logic [2:0]   qm_snap_reg;
    logic [3:0]   qe_snap_reg;
    logic         qlow_snap_reg;
    logic [127:0] wt_snap_reg;

    logic [11:0]  qp_prod;
    logic [3:0]   qe_next;
    logic [2:0]   qm_next;

    logic [63:0]  row_store_reg [4];
    logic [1:0]   row_cnt_reg;
    logic [2:0]   issue_cnt_reg;
    logic [1:0]   out_row_reg;

    pctl_t        p0_ctl;
    pctl_t        p1_ctl_reg;
    pctl_t        p2_ctl_reg;
    pctl_t        m_ctl;

    logic         in_xfer;
    logic         out_xfer;

    logic [3:0]   lane_pos [4];
    wvec_t        lane_val;
    svec_t        m_row;

    svec_t        harr_reg [4];
    svec_t        res_reg [4];
    wvec_t        col_in [4];
    wvec_t        col_out [4];
    svec_t        vert_row [4];

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // qp split into table row and shift
    assign qp_prod = 12'(qp_reg) * 12'(QP_DIV6_MUL);
    assign qe_next = qp_prod[11:8];
    assign qm_next = 3'(qp_reg - 6'(qe_next) * 6'd6);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            qp_reg    <= QP_RESET;
            wlow_reg  <= WEIGHT_RESET;
            whigh_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_QP:    qp_reg    <= cfg_data[5:0];
                CFG_WLOW:  wlow_reg  <= cfg_data;
                CFG_WHIGH: whigh_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // snapshot and row store
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            row_store_reg[row_cnt_reg] <= {coeff_d, coeff_c, coeff_b, coeff_a};
            if (row_cnt_reg == 2'd3)
            begin
                dq_snap_reg     <= (mode_reg == MODE_FULL) || (mode_reg == MODE_DEQ);
                bypass_snap_reg <= (mode_reg == MODE_DEQ);
                qm_snap_reg     <= qm_next;
                qe_snap_reg     <= qe_next;
                qlow_snap_reg   <= (qp_reg < QP_SPLIT);
                wt_snap_reg     <= {whigh_reg, wlow_reg};
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && row_cnt_reg == 2'd3)
                begin
                    state_next = ST_ROWS;
                end
            end
            ST_ROWS:
            begin
                if (m_ctl.valid && m_ctl.row == 2'd3)
                begin
                    state_next = ST_COLS;
                end
            end
            ST_COLS:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_xfer && out_row_reg == 2'd3)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != ST_LOAD);
        out_valid    = (state_reg == ST_SEND);
        p0_ctl.valid = (state_reg == ST_ROWS) && !issue_cnt_reg[2];
        p0_ctl.row   = issue_cnt_reg[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            row_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            out_row_reg   <= '0;
            p1_ctl_reg    <= '0;
            p2_ctl_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_ctl_reg <= p0_ctl;
            p2_ctl_reg <= p1_ctl_reg;
            if (in_xfer)
            begin
                row_cnt_reg <= row_cnt_reg + 2'd1;
            end
            if (state_reg != ST_ROWS)
            begin
                issue_cnt_reg <= '0;
            end
            else if (p0_ctl.valid)
            begin
                issue_cnt_reg <= issue_cnt_reg + 3'd1;
            end
            if (out_xfer)
            begin
                out_row_reg <= out_row_reg + 2'd1;
            end
        end
    end

    // column lanes
    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        assign lane_pos[c] = {issue_cnt_reg[1:0], 2'(c)};

        itd_lane u_lane (
            .clk    (clk),
            .coef   (row_store_reg[issue_cnt_reg[1:0]][16*c +: 16]),
            .cls    (POS_CLASS[lane_pos[c]]),
            .weight (wt_snap_reg[{lane_pos[c], 3'b000} +: 8]),
            .qm     (qm_snap_reg),
            .qe     (qe_snap_reg),
            .qp_low (qlow_snap_reg),
            .use_dq (dq_snap_reg),
            .dq_val (lane_val[c])
        );
    end

    itd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (p2_ctl_reg),
        .bypass   (bypass_snap_reg),
        .lane_val (lane_val),
        .ctl_out  (m_ctl),
        .row_out  (m_row)
    );

    always_ff @(posedge clk)
    begin
        if (m_ctl.valid)
        begin
            harr_reg[m_ctl.row] <= m_row;
        end
    end

    // vertical pass, one butterfly per column
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                col_in[c][r] = 32'($signed(harr_reg[r][c]));
            end
            col_out[c] = butterfly(col_in[c]);
            for (int r = 0; r < 4; r++)
            begin
                vert_row[r][c] = 16'(($signed(col_out[c][r]) + ROUND_BIAS) >>> VERT_SHIFT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COLS)
        begin
            for (int r = 0; r < 4; r++)
            begin
                res_reg[r] <= bypass_snap_reg ? harr_reg[r] : vert_row[r];
            end
        end
    end

    assign out_a      = res_reg[out_row_reg][0];
    assign out_b      = res_reg[out_row_reg][1];
    assign out_c      = res_reg[out_row_reg][2];
    assign out_d      = res_reg[out_row_reg][3];
    assign out_row    = out_row_reg;
    assign block_last = (out_row_reg == 2'd3);

    a_no_input_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result rows pending");

    a_merge_only_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        m_ctl.valid |-> (state_reg == ST_ROWS))
        else $error("row pipeline output outside row phase");

    a_partial_block_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (row_cnt_reg != 2'd0) |-> (state_reg == ST_LOAD))
        else $error("row count nonzero outside load phase");

    a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && block_last) |=> (state_reg == ST_LOAD && out_row_reg == 2'd0))
        else $error("block end did not return to load");

endmodule

`default_nettype wire

/* bench/inverse_4x4_integer_transform_dequant_tb.sv */
// ---------------------------------------------------------------------------
// inverse_4x4_integer_transform_dequant_tb: self-checking bench for the 4x4
// inverse transform with dequantization
// Coefficient rows go out from a queue through a clocked driver. A predictor
// keeps its own row buffer and register copy, and pushes four expected result
// rows whenever a block completes. A clocked monitor checks every result row
// in order. Directed blocks cover extremes, all modes, qp limits, an ignored
// register index and a config change mid-block. Random phases then vary the
// config and the idle/stall pressure on both channels.
// ---------------------------------------------------------------------------
module inverse_4x4_integer_transform_dequant_tb;

    import itd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned ROWS_PER_PHASE = 13;
    localparam logic [2:0]  CFG_UNUSED   = 3'd5;
    localparam logic [1:0]  MODE_SPARE   = 2'd3;

    // level normalization per qp%6 and position class
    localparam int unsigned LEVEL_NORM [6][3] = '{
        '{10, 16, 13},
        '{11, 18, 14},
        '{13, 20, 16},
        '{14, 23, 18},
        '{16, 25, 20},
        '{18, 29, 23}
    };
    localparam int unsigned POS_KIND [16] = '{
        0, 2, 0, 2,
        2, 1, 2, 1,
        0, 2, 0, 2,
        2, 1, 2, 1
    };

    typedef struct packed {
        smp_t a;
        smp_t b;
        smp_t c;
        smp_t d;
    } coeff_row_t;

    typedef struct packed {
        smp_t       a;
        smp_t       b;
        smp_t       c;
        smp_t       d;
        logic [1:0] row;
        logic       last;
    } pixel_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    smp_t        coeff_a = '0;
    smp_t        coeff_b = '0;
    smp_t        coeff_c = '0;
    smp_t        coeff_d = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    smp_t        out_a;
    smp_t        out_b;
    smp_t        out_c;
    smp_t        out_d;
    logic [1:0]  out_row;
    logic        block_last;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    coeff_row_t  rows_to_send [$];
    pixel_row_t  rows_expected [$];
    coeff_row_t  next_row;
    pixel_row_t  want_row;
    pixel_row_t  got_row;

    // register shadow and row buffer of the predictor
    logic [1:0]  cur_mode = MODE_FULL;
    logic [5:0]  cur_qp = 6'd1;
    logic [63:0] cur_wlow = 64'h1010_1010_1010_1010;
    logic [63:0] cur_whigh = 64'h1010_1010_1010_1010;
    logic [63:0] row_buf [4];
    logic [1:0]  row_cnt = 2'd0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned stray_cnt = 0;
    int unsigned cycle_cnt = 0;

    inverse_4x4_integer_transform_dequant i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coeff_a    (coeff_a),
        .coeff_b    (coeff_b),
        .coeff_c    (coeff_c),
        .coeff_d    (coeff_d),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_a      (out_a),
        .out_b      (out_b),
        .out_c      (out_c),
        .out_d      (out_d),
        .out_row    (out_row),
        .block_last (block_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] dequant_coeff(input logic [31:0] c, input int unsigned pos);
        int unsigned qm;
        int unsigned qe;
        logic [31:0] wgt;
        logic [31:0] lvl;
        logic [31:0] x;
        qm = cur_qp % 6;
        qe = cur_qp / 6;
        wgt = (pos < 8) ? 32'(cur_wlow[8*pos +: 8]) : 32'(cur_whigh[8*(pos-8) +: 8]);
        lvl = LEVEL_NORM[qm][POS_KIND[pos]] * wgt;
        x = c * lvl;
        if (cur_qp < 6'd24)
        begin
            x = x + (32'd1 << (3 - qe));
            x = $signed(x) >>> (4 - qe);
        end
        else
            x = x << (qe - 4);
        return x;
    endfunction

    // one 1-D inverse core transform at 32 bits, result {o3, o2, o1, o0}
    function automatic logic [127:0] inv_core_1d(input logic [31:0] v0, input logic [31:0] v1,
                                                 input logic [31:0] v2, input logic [31:0] v3);
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] f0;
        logic [31:0] f1;
        logic [31:0] h1;
        logic [31:0] h3;
        // halve on their own so the shifts stay arithmetic
        h1 = $signed(v1) >>> 1;
        h3 = $signed(v3) >>> 1;
        e0 = v0 + v2;
        e1 = v0 - v2;
        f0 = h1 - v3;
        f1 = v1 + h3;
        return {e0 - f1, e1 - f0, e1 + f0, e0 + f1};
    endfunction

    task automatic take_coeff_row(input coeff_row_t cr);
        logic signed [31:0] blk [16];
        logic [127:0] o;
        logic [31:0]  t;
        pixel_row_t   pr;
        row_buf[row_cnt] = {cr.d, cr.c, cr.b, cr.a};
        if (row_cnt != 2'd3)
            row_cnt = row_cnt + 2'd1;
        else
        begin
            row_cnt = 2'd0;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    blk[r*4+c] = 32'($signed(row_buf[r][16*c +: 16]));
            if (cur_mode == MODE_DEQ)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    t = dequant_coeff(blk[i], i);
                    blk[i] = 32'($signed(t[15:0]));
                end
            end
            else
            begin
                if (cur_mode == MODE_FULL)
                    for (int i = 0; i < 16; i++)
                        blk[i] = dequant_coeff(blk[i], i);
                for (int r = 0; r < 4; r++)
                begin
                    o = inv_core_1d(blk[r*4], blk[r*4+1], blk[r*4+2], blk[r*4+3]);
                    for (int c = 0; c < 4; c++)
                        blk[r*4+c] = 32'($signed(o[32*c +: 16]));
                end
                for (int c = 0; c < 4; c++)
                begin
                    o = inv_core_1d(blk[c], blk[4+c], blk[8+c], blk[12+c]);
                    for (int r = 0; r < 4; r++)
                    begin
                        t = $signed(o[32*r +: 32]) + 32;
                        t = $signed(t) >>> 6;
                        blk[r*4+c] = 32'($signed(t[15:0]));
                    end
                end
            end
            for (int r = 0; r < 4; r++)
            begin
                pr.a = blk[r*4][15:0];
                pr.b = blk[r*4+1][15:0];
                pr.c = blk[r*4+2][15:0];
                pr.d = blk[r*4+3][15:0];
                pr.row = r[1:0];
                pr.last = (r == 3);
                rows_expected.push_back(pr);
            end
        end
    endtask

    // input channel: hold the payload while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_coeff_row('{coeff_a, coeff_b, coeff_c, coeff_d});
            if (!in_valid || !in_stall)
            begin
                if (rows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_row = rows_to_send.pop_front();
                    in_valid <= 1'b1;
                    coeff_a  <= next_row.a;
                    coeff_b  <= next_row.b;
                    coeff_c  <= next_row.c;
                    coeff_d  <= next_row.d;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output channel: check each transfer against the oldest expected row
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_row = '{out_a, out_b, out_c, out_d, out_row, block_last};
                if (rows_expected.size() == 0)
                begin
                    stray_cnt++;
                    $display("unexpected result row %0d: %0d %0d %0d %0d",
                             out_row, out_a, out_b, out_c, out_d);
                end
                else
                begin
                    want_row = rows_expected.pop_front();
                    if (got_row.a !== want_row.a || got_row.b !== want_row.b ||
                        got_row.c !== want_row.c || got_row.d !== want_row.d ||
                        got_row.row !== want_row.row || got_row.last !== want_row.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp row %0d last %0d [%0d %0d %0d %0d],",
                                     want_row.row, want_row.last, want_row.a, want_row.b,
                                     want_row.c, want_row.d,
                                     " got row %0d last %0d [%0d %0d %0d %0d]",
                                     got_row.row, got_row.last,
                                     got_row.a, got_row.b, got_row.c, got_row.d);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:  cur_mode  = val[1:0];
            CFG_QP:    cur_qp    = val[5:0];
            CFG_WLOW:  cur_wlow  = val;
            CFG_WHIGH: cur_whigh = val;
            default: ;
        endcase
    endtask

    task automatic queue_row(input int a, input int b, input int c, input int d);
        coeff_row_t cr;
        cr = '{16'(a), 16'(b), 16'(c), 16'(d)};
        rows_to_send.push_back(cr);
    endtask

    // wait until every row is sent and every result row has come back
    task automatic settle();
        do
            @(negedge clk);
        while (rows_to_send.size() != 0 || in_valid || rows_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_coeff();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 40)
            return int'($urandom_range(128)) - 64;
        else if (k < 55)
            return int'($urandom_range(4095)) - 2048;
        else if (k < 85)
            return int'($urandom_range(65535)) - 32768;
        else
            return $urandom_range(1) ? 32767 : -32768;
    endfunction

    function automatic logic [63:0] pick_weights();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0)
            return '1;
        else if (k == 1)
            return 64'h1010_1010_1010_1010;
        else if (k == 2)
            return '0;
        else
            return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset config, extremes
        queue_row(32767, -32768, 32767, -32768);
        queue_row(-32768, 32767, -32768, 32767);
        queue_row(0, 0, 0, 0);
        queue_row(1, -1, 2, -2);
        settle();

        write_reg(CFG_MODE, {62'h3FFF_FFFF_FFFF_FFFF, MODE_XFORM});
        queue_row(32767, 32767, 32767, 32767);
        queue_row(-32768, -32768, -32768, -32768);
        queue_row(32767, 0, -32768, 0);
        queue_row(-1, -1, -1, -1);
        settle();

        // dequant only at the top of the qp range, full and zero weights
        write_reg(CFG_MODE, {62'd0, MODE_DEQ});
        write_reg(CFG_QP, 64'd63);
        write_reg(CFG_WLOW, '1);
        write_reg(CFG_WHIGH, '0);
        queue_row(1, -1, 255, -256);
        queue_row(32767, -32768, 7, -7);
        queue_row(100, -100, 3, -3);
        queue_row(-32768, 32767, 0, 1);
        settle();

        // unused mode value falls back to transform only
        write_reg(CFG_MODE, {62'd0, MODE_SPARE});
        write_reg(CFG_QP, 64'hFFFF_FFFF_FFFF_FFC0);
        queue_row(4660, -4660, 22136, -22136);
        queue_row(-1, 1, -2, 2);
        queue_row(16384, -16384, 8192, -8192);
        queue_row(32767, 32767, -32768, -32768);
        settle();

        // out-of-range register index is ignored; qp changes mid-block
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_MODE, {62'd0, MODE_FULL});
        write_reg(CFG_QP, 64'd51);
        write_reg(CFG_WLOW, 64'h1010_1010_1010_1010);
        write_reg(CFG_WHIGH, 64'h0102_0408_1020_4080);
        queue_row(10, -10, 5, -5);
        queue_row(3, 3, -3, -3);
        settle();
        write_reg(CFG_QP, 64'd24);
        write_reg(CFG_WLOW, 64'h80FF_7F01_00FE_8081);
        queue_row(-32768, 0, 0, 32767);
        queue_row(2, -2, 1, -1);
        settle();

        write_reg(CFG_QP, 64'd23);
        write_reg(CFG_WLOW, {$urandom(), $urandom()});
        for (int i = 0; i < 4; i++)
            queue_row(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
        settle();

        // random phases; a phase may end mid-block so config also changes there
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            write_reg(CFG_MODE, {$urandom(), 30'($urandom()), 2'($urandom_range(3))});
            write_reg(CFG_QP,
                      64'(($urandom_range(9) < 7) ? $urandom_range(51) : $urandom_range(63)));
            if (ph == 0)
            begin
                write_reg(CFG_QP, 64'd0);
                write_reg(CFG_MODE, {62'd0, MODE_FULL});
            end
            write_reg(CFG_WLOW, pick_weights());
            write_reg(CFG_WHIGH, pick_weights());
            for (int i = 0; i < ROWS_PER_PHASE; i++)
                queue_row(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
            settle();
        end

        if (mismatch_cnt == 0 && stray_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/itd_pkg.sv
rtl/itd_lane.sv
rtl/itd_merge.sv
rtl/inverse_4x4_integer_transform_dequant.sv
bench/inverse_4x4_integer_transform_dequant_tb.sv
